// ----- design/bfpw_pkg.sv -----
package bfpw_pkg;

    localparam int unsigned KB_SHIFT  = 10;
    localparam int unsigned COMP_BITS = 8;
    localparam int unsigned DIV_STEPS = 32 - KB_SHIFT;

    localparam logic [2:0] REG_SCREEN_WIDTH   = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_BYTES_PER_LINE = 3'd2;
    localparam logic [2:0] REG_PIXEL_BYTES    = 3'd3;
    localparam logic [2:0] REG_GRANULARITY_KB = 3'd4;
    localparam logic [2:0] REG_WINDOW_KB      = 3'd5;
    localparam logic [2:0] REG_COLOR_LAYOUT   = 3'd6;
    localparam logic [2:0] REG_WINDOW_SELECT  = 3'd7;

    typedef struct packed {
        logic [15:0] screen_width;
        logic [15:0] screen_height;
        logic [15:0] bytes_per_line;
        logic [2:0]  pixel_bytes;
        logic [6:0]  granularity_kb;
        logic [6:0]  window_kb;
        logic [47:0] color_layout;
        logic        window_select;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic do_mul;
        logic do_add;
        logic do_check;
        logic div_start;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic visible;
        logic miss;
        logic div_done;
        logic out_free;
    } t_sts;

    function automatic logic [2:0] eff_pixel_bytes(input logic [2:0] pb);
        logic [2:0] r;
        r = pb;
        if (pb == 3'd0) r = 3'd1;
        if (pb > 3'd4) r = 3'd4;
        return r;
    endfunction

    function automatic logic [31:0] place_comp(input logic [7:0] comp,
                                               input logic [7:0] size,
                                               input logic [7:0] pos);
        logic [7:0]  v;
        logic [31:0] r;
        v = comp;
        r = 32'd0;
        if (size < 8'(COMP_BITS)) begin
            v = comp >> (4'(COMP_BITS) - size[3:0]);
        end
        if (size != 8'd0 && pos < 8'd32) begin
            r = {24'd0, v} << pos[4:0];
        end
        return r;
    endfunction

endpackage

// ----- design/bfpw_ctrl.sv -----
module bfpw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bfpw_pkg::t_sts i_sts,
    output bfpw_pkg::t_cmd o_cmd
);
    import bfpw_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.do_mul = 1'b1;
                n_state      = i_sts.visible ? S_ADD : S_IDLE;
            end
            S_ADD: begin
                o_cmd.do_add = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.do_check = 1'b1;
                if (i_sts.miss) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/bfpw_dp.sv -----
module bfpw_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bfpw_pkg::t_cfg i_cfg,
    input  bfpw_pkg::t_cmd i_cmd,
    output bfpw_pkg::t_sts o_sts,
    input  logic [55:0]    i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [71:0]    o_out_data
);
    import bfpw_pkg::*;

    logic [15:0] r_x, r_y;
    logic [7:0]  r_red, r_green, r_blue;
    logic [30:0] r_prod_y;
    logic [17:0] r_prod_x;
    logic [31:0] r_color;
    logic [31:0] r_offset;
    logic        r_miss;
    logic [31:0] r_window_base;
    logic [21:0] r_dq;
    logic [6:0]  r_rem;
    logic [4:0]  r_cnt;
    logic        r_out_valid;
    logic [71:0] r_out_data;

    logic [2:0]  pb;
    logic [6:0]  gran;
    logic [32:0] win_hi;
    logic        miss;
    logic [7:0]  trial;
    logic        q_bit;
    logic [6:0]  n_rem;
    logic [31:0] color;
    logic [15:0] bank;
    logic [15:0] wr_off;
    logic [21:0] base_kb;

    assign pb   = eff_pixel_bytes(i_cfg.pixel_bytes);
    assign gran = (i_cfg.granularity_kb == 7'd0) ? 7'd1 : i_cfg.granularity_kb;

    assign o_sts.visible = !r_x[15] && !r_y[15] && (r_x < i_cfg.screen_width)
                           && (r_y < i_cfg.screen_height);

    assign win_hi = {1'b0, r_window_base} + {16'd0, i_cfg.window_kb, 10'd0};
    assign miss   = !(r_offset >= r_window_base && {1'b0, r_offset} < win_hi);
    assign o_sts.miss     = miss;
    assign o_sts.div_done = (r_cnt == 5'(DIV_STEPS - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign trial = {r_rem, r_dq[21]};
    assign q_bit = (trial >= {1'b0, gran});
    assign n_rem = q_bit ? 7'(trial - {1'b0, gran}) : trial[6:0];

    assign color = place_comp(r_red,   i_cfg.color_layout[7:0],   i_cfg.color_layout[31:24])
                 | place_comp(r_green, i_cfg.color_layout[15:8],  i_cfg.color_layout[39:32])
                 | place_comp(r_blue,  i_cfg.color_layout[23:16], i_cfg.color_layout[47:40]);

    assign base_kb = r_offset[31:10] - {15'd0, r_rem};
    assign bank    = r_miss ? r_dq[15:0] : 16'd0;
    assign wr_off  = r_miss ? {r_rem[5:0], r_offset[9:0]}
                            : (r_offset[15:0] - r_window_base[15:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x     <= i_in_data[15:0];
            r_y     <= i_in_data[31:16];
            r_red   <= i_in_data[39:32];
            r_green <= i_in_data[47:40];
            r_blue  <= i_in_data[55:48];
        end
        if (i_cmd.do_mul) begin
            r_prod_y <= {16'd0, r_y[14:0]} * {15'd0, i_cfg.bytes_per_line};
            r_prod_x <= {3'd0, r_x[14:0]} * {15'd0, pb};
            r_color  <= color;
        end
        if (i_cmd.do_add) begin
            r_offset <= {1'b0, r_prod_y} + {14'd0, r_prod_x};
        end
        if (i_cmd.do_check) begin
            r_miss <= miss;
        end
        if (i_cmd.div_start) begin
            r_dq  <= r_offset[31:10];
            r_rem <= 7'd0;
            r_cnt <= 5'd0;
        end else if (i_cmd.div_step) begin
            r_dq  <= {r_dq[20:0], q_bit};
            r_rem <= n_rem;
            r_cnt <= r_cnt + 5'd1;
        end
        if (i_cmd.finish) begin
            r_out_data <= {3'd0, pb, r_color, wr_off, i_cfg.window_select, bank, r_miss};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_base <= 32'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.finish && r_miss) begin
                r_window_base <= {base_kb, 10'd0};
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- design/banked_framebuffer_pixel_writer.sv -----
// Banked framebuffer pixel writer.
// Input stream s_axis carries one pixel per transaction: signed x, y and 8-bit
// red, green, blue. Pixels outside the configured screen are dropped silently.
// Each visible pixel gives one transaction on m_axis: bank switch flag and bank
// number, window select, window-relative write offset, packed color word and
// byte count. Registers are written through i_cfg_wdata/i_cfg_addr/i_cfg_we;
// the user must do so only while the block is idle; the block does not check it.
// On a window miss the bank index comes out of a one-bit-per-cycle divider
// (22 steps); an offset inside the current window skips the divider. A visible
// pixel passes the multiply, add, check and finish states, with the divide state
// between check and finish on a miss; a dropped pixel leaves after multiply. One
// pixel is worked on at a time; the next one is taken as soon as the previous
// result is parked in the output register.
// If m_axis stalls, the finished result holds in the output register; one more
// pixel may be processed and then waits until the register frees.
// Synchronous reset restores register defaults and places the window at 0.
module banked_framebuffer_pixel_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [47:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pixel_x[15:0], pixel_y[31:16], red[39:32], green[47:40], blue[55:48]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // bank_switch[0], bank_number[16:1], window_select_out[17],
    // write_offset[33:18], color_word[65:34], byte_count[68:66]
    output logic [71:0] m_axis_tdata
);
    import bfpw_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width   <= 16'd640;
            r_cfg.screen_height  <= 16'd480;
            r_cfg.bytes_per_line <= 16'd1280;
            r_cfg.pixel_bytes    <= 3'd2;
            r_cfg.granularity_kb <= 7'd64;
            r_cfg.window_kb      <= 7'd64;
            r_cfg.color_layout   <= 48'd0;
            r_cfg.window_select  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SCREEN_WIDTH:   r_cfg.screen_width   <= i_cfg_wdata[15:0];
                REG_SCREEN_HEIGHT:  r_cfg.screen_height  <= i_cfg_wdata[15:0];
                REG_BYTES_PER_LINE: r_cfg.bytes_per_line <= i_cfg_wdata[15:0];
                REG_PIXEL_BYTES:    r_cfg.pixel_bytes    <= i_cfg_wdata[2:0];
                REG_GRANULARITY_KB: r_cfg.granularity_kb <= i_cfg_wdata[6:0];
                REG_WINDOW_KB:      r_cfg.window_kb      <= i_cfg_wdata[6:0];
                REG_COLOR_LAYOUT:   r_cfg.color_layout   <= i_cfg_wdata;
                REG_WINDOW_SELECT:  r_cfg.window_select  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    bfpw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bfpw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ----- verif/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfpw_pkg::*;

    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASES         = 12;
    localparam int PIXELS_A_PHASE = 125;
    localparam int HOLD_AT_RESULT = 150;
    localparam int HOLD_CYCLES    = 600;

    typedef struct packed {
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_pixel;

    typedef struct packed {
        logic [2:0]  pad;
        logic [2:0]  byte_count;
        logic [31:0] color_word;
        logic [15:0] write_offset;
        logic        window_sel;
        logic [15:0] bank_number;
        logic        bank_switch;
    } t_pix_write;

    typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_DROP, ROW_RES} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  addr;
        logic [47:0] value;
        t_pixel      px;
        t_pix_write  res;
    } t_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [2:0]  i_cfg_addr    = REG_SCREEN_WIDTH;
    logic [47:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;  // pixel_x, pixel_y, red, green, blue
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // bank_switch, bank_number, window_select_out, write_offset, color_word, byte_count
    logic [71:0] m_axis_tdata;

    t_cfg        cfg_q;
    logic [31:0] win_base;
    t_pix_write  pending_writes[$];
    t_row        stim_table[$];
    int          errors       = 0;
    int          pixels_sent  = 0;
    int          writes_seen  = 0;
    int          tx_mode      = 0;
    int          rx_mode      = 1;

    banked_framebuffer_pixel_writer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int draw_gap(input int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 15);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
        endcase
    endfunction

    function automatic logic [31:0] color_field(input logic [7:0] comp, input logic [7:0] sz,
                                                input logic [7:0] pos);
        logic [63:0] v;
        v = {56'd0, comp};
        if (sz == 8'd0 || pos >= 8'd32) return 32'd0;
        if (sz < 8'd8) v = v >> (8 - sz);
        v = v << pos;
        return v[31:0];
    endfunction

    // returns 0 for a clipped pixel; updates the window position on a miss
    function automatic bit render_pixel(input t_pixel p, output t_pix_write w);
        logic [63:0] pb;
        logic [63:0] gran;
        logic [63:0] win;
        logic [63:0] ofs;
        logic [63:0] bank;
        logic [63:0] base;
        logic [31:0] color;
        bit          moved;
        w = '0;
        if (p.x[15] || p.y[15] || $unsigned(p.x) >= cfg_q.screen_width ||
            $unsigned(p.y) >= cfg_q.screen_height) return 1'b0;
        pb = 64'(cfg_q.pixel_bytes);
        if (pb == 0) pb = 1;
        if (pb > 4) pb = 4;
        color = color_field(p.red,   cfg_q.color_layout[7:0],   cfg_q.color_layout[31:24])
              | color_field(p.green, cfg_q.color_layout[15:8],  cfg_q.color_layout[39:32])
              | color_field(p.blue,  cfg_q.color_layout[23:16], cfg_q.color_layout[47:40]);
        ofs  = 64'($unsigned(p.y)) * 64'(cfg_q.bytes_per_line) + 64'($unsigned(p.x)) * pb;
        gran = ((cfg_q.granularity_kb == 7'd0) ? 64'd1 : 64'(cfg_q.granularity_kb)) << KB_SHIFT;
        win  = 64'(cfg_q.window_kb) << KB_SHIFT;
        base = 64'(win_base);
        bank = 0;
        moved = 1'b0;
        if (!(ofs >= base && ofs < base + win)) begin
            bank = ofs / gran;
            win_base = 32'(bank * gran);
            moved = 1'b1;
        end
        w.bank_switch  = moved;
        w.bank_number  = bank[15:0];
        w.window_sel   = cfg_q.window_select;
        w.write_offset = 16'(ofs - 64'(win_base));
        w.color_word   = color;
        w.byte_count   = pb[2:0];
        return 1'b1;
    endfunction

    function automatic t_pix_write mk_write(input int sw, input int bank, input int ws,
                                            input int wo, input logic [31:0] color,
                                            input int bc);
        t_pix_write w;
        w = '0;
        w.bank_switch  = 1'(sw);
        w.bank_number  = 16'(bank);
        w.window_sel   = 1'(ws);
        w.write_offset = 16'(wo);
        w.color_word   = color;
        w.byte_count   = 3'(bc);
        return w;
    endfunction

    function automatic t_row cfg_row(input logic [2:0] idx, input logic [47:0] val);
        t_row row;
        row.kind  = ROW_CFG;
        row.addr  = idx;
        row.value = val;
        row.px    = '0;
        row.res   = '0;
        return row;
    endfunction

    function automatic t_row pix_row(input t_row_kind k, input int x, input int y,
                                     input int r, input int g, input int b,
                                     input t_pix_write w = '0);
        t_row row;
        row.kind     = k;
        row.addr     = REG_SCREEN_WIDTH;
        row.value    = '0;
        row.px.x     = 16'(x);
        row.px.y     = 16'(y);
        row.px.red   = 8'(r);
        row.px.green = 8'(g);
        row.px.blue  = 8'(b);
        row.res      = w;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("%0t: write #%0d %s: got 0x%0h, expected 0x%0h",
                 $time, writes_seen, what, got, want);
    endtask

    task automatic check_write(input t_pix_write got);
        t_pix_write e;
        if (pending_writes.size() == 0) begin
            report_mismatch("unexpected transaction, write_offset",
                            32'(got.write_offset), 32'd0);
            return;
        end
        e = pending_writes.pop_front();
        if (got.bank_switch !== e.bank_switch)
            report_mismatch("bank_switch", 32'(got.bank_switch), 32'(e.bank_switch));
        if (got.bank_number !== e.bank_number)
            report_mismatch("bank_number", 32'(got.bank_number), 32'(e.bank_number));
        if (got.window_sel !== e.window_sel)
            report_mismatch("window_select_out", 32'(got.window_sel), 32'(e.window_sel));
        if (got.write_offset !== e.write_offset)
            report_mismatch("write_offset", 32'(got.write_offset), 32'(e.write_offset));
        if (got.color_word !== e.color_word)
            report_mismatch("color_word", got.color_word, e.color_word);
        if (got.byte_count !== e.byte_count)
            report_mismatch("byte_count", 32'(got.byte_count), 32'(e.byte_count));
        if (got.pad !== 3'd0)
            report_mismatch("tdata padding", 32'(got.pad), 32'd0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_SCREEN_WIDTH:   cfg_q.screen_width   = val[15:0];
            REG_SCREEN_HEIGHT:  cfg_q.screen_height  = val[15:0];
            REG_BYTES_PER_LINE: cfg_q.bytes_per_line = val[15:0];
            REG_PIXEL_BYTES:    cfg_q.pixel_bytes    = val[2:0];
            REG_GRANULARITY_KB: cfg_q.granularity_kb = val[6:0];
            REG_WINDOW_KB:      cfg_q.window_kb      = val[6:0];
            REG_COLOR_LAYOUT:   cfg_q.color_layout   = val;
            REG_WINDOW_SELECT:  cfg_q.window_select  = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_pixel(input t_pixel p, input t_row_kind kind, input t_pix_write typed,
                              output bit shown);
        int         gap;
        t_pix_write w;
        gap = draw_gap(tx_mode);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        shown = render_pixel(p, w);
        if (kind == ROW_RES) pending_writes.push_back(typed);
        else if (shown && kind != ROW_DROP) pending_writes.push_back(w);
        pixels_sent++;
        if (pixels_sent % 64 == 0) tx_mode = $urandom_range(0, 2);
    endtask

    task automatic pick_config(input int ph);
        logic [15:0] sw;
        logic [15:0] sh;
        logic [15:0] bpl;
        logic [2:0]  pb;
        logic [6:0]  gk;
        logic [6:0]  wk;
        logic [47:0] lay;
        for (int k = 0; k < 3; k++) begin
            lay[8*k +: 8]     = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                                8'($urandom_range(0, 9));
            lay[8*k + 24 +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                                 8'($urandom_range(0, 31));
        end
        if (ph % 5 == 4) lay = {16'($urandom), 32'($urandom)};
        case (ph)
            0: begin
                sw = 16'hFFFF; sh = 16'hFFFF; bpl = 16'hFFFF;
                pb = 3'd4; gk = 7'd1; wk = 7'd1;
            end
            1: begin
                sw = 16'd1; sh = 16'd1; bpl = 16'd0;
                pb = 3'd1; gk = 7'h7F; wk = 7'h7F;
            end
            2: begin
                sw = 16'hFFFF; sh = 16'd3; bpl = 16'd1;
                pb = 3'd7; gk = 7'd0; wk = 7'd0;
            end
            default: begin
                sw  = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom_range(1, 1024));
                sh  = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom_range(1, 768));
                bpl = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192));
                pb  = 3'($urandom_range(0, 7));
                gk  = 7'($urandom_range(0, 127));
                wk  = 7'($urandom_range(0, 127));
            end
        endcase
        write_reg(REG_SCREEN_WIDTH, 48'(sw));
        write_reg(REG_SCREEN_HEIGHT, 48'(sh));
        write_reg(REG_BYTES_PER_LINE, 48'(bpl));
        write_reg(REG_PIXEL_BYTES, 48'(pb));
        write_reg(REG_GRANULARITY_KB, 48'(gk));
        write_reg(REG_WINDOW_KB, 48'(wk));
        write_reg(REG_COLOR_LAYOUT, lay);
        write_reg(REG_WINDOW_SELECT, 48'(ph % 2));
    endtask

    task automatic build_table();
        // reset settings: 640x480, 1280 bytes/line, 2 bytes/pixel, 64K window, empty layout
        stim_table.push_back(pix_row(ROW_RES, 0, 0, 0, 0, 0, mk_write(0, 0, 0, 0, 0, 2)));
        stim_table.push_back(pix_row(ROW_DROP, -1, 0, 255, 255, 255));
        stim_table.push_back(pix_row(ROW_DROP, 0, -1, 255, 255, 255));
        stim_table.push_back(pix_row(ROW_DROP, 640, 0, 255, 255, 255));
        stim_table.push_back(pix_row(ROW_DROP, 0, 480, 255, 255, 255));
        stim_table.push_back(pix_row(ROW_DROP, -32768, -32768, 0, 0, 0));
        stim_table.push_back(pix_row(ROW_DROP, 32767, 32767, 255, 255, 255));
        stim_table.push_back(pix_row(ROW_RES, 639, 479, 255, 255, 255,
                                     mk_write(1, 9, 0, 24574, 0, 2)));
        stim_table.push_back(pix_row(ROW_RES, 0, 0, 128, 128, 128, mk_write(1, 0, 0, 0, 0, 2)));
        // 5-6-5 layout
        stim_table.push_back(cfg_row(REG_COLOR_LAYOUT, 48'h00050B050605));
        stim_table.push_back(pix_row(ROW_PIX, 1, 1, 255, 128, 127));
        stim_table.push_back(pix_row(ROW_PIX, 638, 1, 8'h55, 8'hAA, 8'h0F));
        // wide red, empty green, blue placed past bit 31, zero pixel bytes
        stim_table.push_back(cfg_row(REG_COLOR_LAYOUT, 48'h20081808000C));
        stim_table.push_back(cfg_row(REG_PIXEL_BYTES, 48'd0));
        stim_table.push_back(pix_row(ROW_PIX, 5, 5, 255, 255, 255));
        stim_table.push_back(pix_row(ROW_PIX, 6, 5, 8'hA5, 8'h5A, 8'hC3));
        // oversize pixel bytes, zero granularity, empty window, window B
        stim_table.push_back(cfg_row(REG_PIXEL_BYTES, 48'd7));
        stim_table.push_back(cfg_row(REG_GRANULARITY_KB, 48'd0));
        stim_table.push_back(cfg_row(REG_WINDOW_KB, 48'd0));
        stim_table.push_back(cfg_row(REG_WINDOW_SELECT, 48'd1));
        stim_table.push_back(cfg_row(REG_COLOR_LAYOUT, 48'h100800FF0907));
        stim_table.push_back(pix_row(ROW_PIX, 0, 0, 8'h81, 8'h7E, 8'hFF));
        stim_table.push_back(pix_row(ROW_PIX, 0, 0, 8'h81, 8'h7E, 8'hFF));
        stim_table.push_back(pix_row(ROW_PIX, 1, 0, 8'h01, 8'h80, 8'h3C));
        // full-size screen, bank index past 16 bits
        stim_table.push_back(cfg_row(REG_SCREEN_WIDTH, 48'hFFFF));
        stim_table.push_back(cfg_row(REG_SCREEN_HEIGHT, 48'hFFFF));
        stim_table.push_back(cfg_row(REG_BYTES_PER_LINE, 48'hFFFF));
        stim_table.push_back(cfg_row(REG_PIXEL_BYTES, 48'd4));
        stim_table.push_back(cfg_row(REG_GRANULARITY_KB, 48'd1));
        stim_table.push_back(cfg_row(REG_WINDOW_KB, 48'd1));
        stim_table.push_back(cfg_row(REG_WINDOW_SELECT, 48'd0));
        stim_table.push_back(pix_row(ROW_PIX, 32767, 32767, 255, 0, 255));
        stim_table.push_back(pix_row(ROW_PIX, 16'h5555, 16'h2AAA, 8'h5A, 8'hA5, 8'h33));
        stim_table.push_back(pix_row(ROW_PIX, -32768, 0, 1, 2, 3));
        // granule larger than window: offset lands past window end
        stim_table.push_back(cfg_row(REG_GRANULARITY_KB, 48'd64));
        stim_table.push_back(cfg_row(REG_WINDOW_KB, 48'd4));
        stim_table.push_back(pix_row(ROW_PIX, 0, 3, 9, 8, 7));
        stim_table.push_back(pix_row(ROW_PIX, 2, 3, 6, 5, 4));
    endtask

    initial begin : result_sink
        int         stall;
        t_pix_write got;
        stall = draw_gap(rx_mode);
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
            end
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                writes_seen++;
                check_write(got);
                stall = (writes_seen == HOLD_AT_RESULT) ? HOLD_CYCLES : draw_gap(rx_mode);
                if (writes_seen % 64 == 0) rx_mode = $urandom_range(0, 2);
            end
        end
    end

    initial begin : pixel_source
        t_pixel p;
        bit     shown;
        int     shown_n;
        int     lim_x;
        int     lim_y;
        int     cx;
        int     cy;
        cfg_q = '{screen_width: 16'd640, screen_height: 16'd480, bytes_per_line: 16'd1280,
                  pixel_bytes: 3'd2, granularity_kb: 7'd64, window_kb: 7'd64,
                  color_layout: 48'd0, window_select: 1'b0};
        win_base = 32'd0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        build_table();
        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_CFG) begin
                if (i == 0 || stim_table[i-1].kind != ROW_CFG) settle();
                write_reg(stim_table[i].addr, stim_table[i].value);
            end else begin
                send_pixel(stim_table[i].px, stim_table[i].kind, stim_table[i].res, shown);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            pick_config(ph);
            lim_x = (cfg_q.screen_width > 16'd32768) ? 32768 : int'(cfg_q.screen_width);
            lim_y = (cfg_q.screen_height > 16'd32768) ? 32768 : int'(cfg_q.screen_height);
            cx = 0;
            cy = 0;
            shown_n = 0;
            while (shown_n < PIXELS_A_PHASE) begin
                case ($urandom_range(0, 9))
                    0: begin
                        p.x = 16'($urandom);
                        p.y = 16'($urandom);
                    end
                    1: begin
                        p.x = 16'($urandom_range(0, 1) ? lim_x : lim_x - 1);
                        p.y = 16'($urandom_range(0, 1) ? lim_y : lim_y - 1);
                    end
                    2, 3, 4: begin
                        cx = $urandom_range(0, lim_x - 1);
                        cy = $urandom_range(0, lim_y - 1);
                        p.x = 16'(cx);
                        p.y = 16'(cy);
                    end
                    default: begin
                        cx++;
                        if (cx >= lim_x) begin
                            cx = 0;
                            cy++;
                            if (cy >= lim_y) cy = 0;
                        end
                        p.x = 16'(cx);
                        p.y = 16'(cy);
                    end
                endcase
                p.red   = 8'($urandom);
                p.green = 8'($urandom);
                p.blue  = 8'($urandom);
                send_pixel(p, ROW_PIX, '0, shown);
                if (shown) shown_n++;
            end
        end

        settle();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
